### design/bagd_pkg.sv
// shared types and constants of the box average downscaler
package bagd_pkg;

   // configuration field widths
   localparam int CFG_IN_W   = 11;
   localparam int CFG_OUT_W  = 9;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 16;

   // payload widths
   localparam int PIX_W   = 8;
   localparam int COORD_W = 8;
   localparam int SUM_W   = 28;
   localparam int PROD_W  = 2 * CFG_IN_W;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // parameter defaults
   localparam int DEF_MAX_IN_SIZE  = 1024;
   localparam int DEF_MAX_OUT_SIZE = 256;

   // reset values of the registers
   localparam logic [CFG_IN_W-1:0]  RST_IN_WIDTH   = CFG_IN_W'(320);
   localparam logic [CFG_IN_W-1:0]  RST_IN_HEIGHT  = CFG_IN_W'(240);
   localparam logic [CFG_OUT_W-1:0] RST_OUT_WIDTH  = CFG_OUT_W'(96);
   localparam logic [CFG_OUT_W-1:0] RST_OUT_HEIGHT = CFG_OUT_W'(96);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_IN_WIDTH   = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] REG_IN_HEIGHT  = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] REG_OUT_WIDTH  = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] REG_OUT_HEIGHT = CSR_IDX_W'(3);

   // status codes
   localparam logic STATUS_OK      = 1'b0;
   localparam logic STATUS_BAD_CFG = 1'b1;

   // one queued box job
   typedef struct packed {
      logic                 status;
      logic [SUM_W-1:0]     sum;
      logic [CFG_IN_W-1:0]  w;
      logic [CFG_IN_W-1:0]  h;
      logic [COORD_W-1:0]   x;
      logic [COORD_W-1:0]   y;
      logic                 done;
   } job_type;

   // queue handshake between front and back
   typedef struct packed {
      logic push;
      logic pop;
   } q_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

### design/bagd_if.sv
// channel interfaces of the box average downscaler

interface bagd_req_if;
   logic                      valid;
   logic                      ready;
   logic [bagd_pkg::PIX_W-1:0] pixel;
   logic                      frame_start;
   modport source (output valid, output pixel, output frame_start, input ready);
   modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface bagd_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bagd_pkg::PIX_W-1:0]   mean_value;
   logic [bagd_pkg::COORD_W-1:0] out_x;
   logic [bagd_pkg::COORD_W-1:0] out_y;
   logic                         frame_done;
   logic                         status;
   modport source (output valid, output mean_value, output out_x, output out_y,
                   output frame_done, output status, input ready);
   modport sink   (input valid, input mean_value, input out_x, input out_y,
                   input frame_done, input status, output ready);
endinterface

interface bagd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [bagd_pkg::CSR_IDX_W-1:0]   index;
   logic [bagd_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

### design/bagd_queue.sv
// short job queue between front and back
module bagd_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  bagd_pkg::q_ctrl_type ctrl,
   input  bagd_pkg::job_type    wr_data,
   output bagd_pkg::job_type    rd_data,
   output bagd_pkg::q_stat_type stat
);
   import bagd_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]     wr_ptr_ff;
   logic [PW-1:0]     rd_ptr_ff;
   logic [PW:0]       count_ff;

   assign stat.full  = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rd_data    = mem_ff[rd_ptr_ff];

   // storage
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (ctrl.push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (ctrl.pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         unique case ({ctrl.push, ctrl.pop})
            2'b10:   count_ff <= count_ff + (PW+1)'(1);
            2'b01:   count_ff <= count_ff - (PW+1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end
endmodule

### design/bagd_front.sv
// front part: configuration, position tracking and column sum accumulation
module bagd_front #(
   parameter int MAX_IN_SIZE  = bagd_pkg::DEF_MAX_IN_SIZE,
   parameter int MAX_OUT_SIZE = bagd_pkg::DEF_MAX_OUT_SIZE
) (
   input  logic                 clock,
   input  logic                 reset,
   bagd_req_if.sink             req_chan,
   bagd_csr_if.sink             csr_chan,
   output logic                 q_push,
   output bagd_pkg::job_type    q_data,
   input  logic                 q_full
);
   import bagd_pkg::*;

   localparam int IW  = $clog2(MAX_IN_SIZE);
   localparam int BCW = (MAX_OUT_SIZE > 1) ? $clog2(MAX_OUT_SIZE) : 1;
   localparam int DCW = $clog2(CFG_IN_W + 1);

   typedef enum logic [1:0] {F_INIT, F_IDLE, F_READ, F_UPD} fstate_type;

   fstate_type              state_ff;
   logic [DCW-1:0]          div_cnt_ff;

   // configuration registers
   logic [CFG_IN_W-1:0]     in_width_ff, in_height_ff;
   logic [CFG_OUT_W-1:0]    out_width_ff, out_height_ff;

   // quotient and remainder of in/out per axis
   logic [CFG_IN_W-1:0]     qw_ff, qh_ff, nw_ff, nh_ff;
   logic [CFG_OUT_W:0]      rw_ff, rh_ff;

   // positions and edges
   logic [IW-1:0]           in_col_ff, in_row_ff;
   logic [BCW-1:0]          box_col_ff;
   logic [COORD_W:0]        box_row_ff;
   logic [CFG_IN_W-1:0]     col_edge_ff, col_prev_ff, row_edge_ff, band_h_ff;
   logic [CFG_OUT_W-1:0]    col_frac_ff, row_frac_ff;

   // pixel being worked on
   logic [PIX_W-1:0]        pix_ff;

   // column sums with one valid bit per entry
   logic [SUM_W-1:0]        sums_mem [MAX_OUT_SIZE];
   logic [SUM_W-1:0]        rd_ff;
   logic [MAX_OUT_SIZE-1:0] sum_vld_ff;

   logic                    sizes_ok, req_acc, csr_acc, csr_hit;
   logic                    box_end, band_end, row_wrap, last_band;
   logic [SUM_W-1:0]        sum_new;
   logic [CFG_OUT_W:0]      tw, th, col_fsum, row_fsum;
   logic                    cw_carry, rh_carry;
   logic [CFG_IN_W-1:0]     col_edge_nx, row_edge_nx, wbox;

   // size check
   always_comb begin
      sizes_ok = 1'b1;
      if (in_width_ff == '0 || in_height_ff == '0 || out_width_ff == '0 ||
          out_height_ff == '0) begin
         sizes_ok = 1'b0;
      end
      if (32'(in_width_ff) > 32'(MAX_IN_SIZE) || 32'(in_height_ff) > 32'(MAX_IN_SIZE)) begin
         sizes_ok = 1'b0;
      end
      if (32'(out_width_ff) > 32'(MAX_OUT_SIZE) ||
          32'(out_height_ff) > 32'(MAX_OUT_SIZE)) begin
         sizes_ok = 1'b0;
      end
      if (CFG_IN_W'(out_width_ff) > in_width_ff || CFG_IN_W'(out_height_ff) > in_height_ff) begin
         sizes_ok = 1'b0;
      end
   end

   assign req_chan.ready = (state_ff == F_IDLE) && !q_full;
   assign csr_chan.ready = 1'b1;
   assign req_acc        = req_chan.valid && req_chan.ready;
   assign csr_acc        = csr_chan.valid;
   assign csr_hit        = csr_acc && (csr_chan.index == REG_IN_WIDTH ||
                           csr_chan.index == REG_IN_HEIGHT || csr_chan.index == REG_OUT_WIDTH ||
                           csr_chan.index == REG_OUT_HEIGHT);

   // restoring division step for the edge increments
   assign tw = {rw_ff[CFG_OUT_W-1:0], nw_ff[CFG_IN_W-1]};
   assign th = {rh_ff[CFG_OUT_W-1:0], nh_ff[CFG_IN_W-1]};

   // accumulation and box tests
   assign sum_new   = (sum_vld_ff[box_col_ff] ? rd_ff : '0) + SUM_W'(pix_ff);
   assign box_end   = (32'(in_col_ff) + 32'd1) >= 32'(col_edge_ff);
   assign band_end  = (32'(in_row_ff) + 32'd1) >= 32'(row_edge_ff);
   assign row_wrap  = (32'(in_col_ff) + 32'd1) >= 32'(in_width_ff);
   assign last_band = (32'(box_row_ff) + 32'd1) >= 32'(out_height_ff);

   // next edges by fractional stepping
   assign col_fsum    = {1'b0, col_frac_ff} + rw_ff;
   assign cw_carry    = col_fsum >= {1'b0, out_width_ff};
   assign col_edge_nx = col_edge_ff + qw_ff + CFG_IN_W'(cw_carry);
   assign row_fsum    = {1'b0, row_frac_ff} + rh_ff;
   assign rh_carry    = row_fsum >= {1'b0, out_height_ff};
   assign row_edge_nx = row_edge_ff + qh_ff + CFG_IN_W'(rh_carry);
   assign wbox        = (col_edge_ff > col_prev_ff) ? (col_edge_ff - col_prev_ff)
                                                    : CFG_IN_W'(1);

   // jobs into the queue
   always_comb begin
      q_push      = 1'b0;
      q_data      = '0;
      q_data.status = STATUS_OK;
      if (state_ff == F_IDLE && req_acc && !sizes_ok) begin
         q_push        = 1'b1;
         q_data.status = STATUS_BAD_CFG;
      end else if (state_ff == F_UPD && box_end && band_end) begin
         q_push      = 1'b1;
         q_data.sum  = sum_new;
         q_data.w    = wbox;
         q_data.h    = (band_h_ff != '0) ? band_h_ff : CFG_IN_W'(1);
         q_data.x    = COORD_W'(box_col_ff);
         q_data.y    = box_row_ff[COORD_W-1:0];
         q_data.done = ((32'(box_col_ff) + 32'd1) >= 32'(out_width_ff)) && last_band;
      end
   end

   // column sum memory
   always_ff @(posedge clock) begin
      if (state_ff == F_READ) begin
         rd_ff <= sums_mem[box_col_ff];
      end
      if (state_ff == F_UPD) begin
         sums_mem[box_col_ff] <= (box_end && band_end) ? '0 : sum_new;
      end
   end

   // control, configuration and positions
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= F_INIT;
         div_cnt_ff    <= '0;
         in_width_ff   <= RST_IN_WIDTH;
         in_height_ff  <= RST_IN_HEIGHT;
         out_width_ff  <= RST_OUT_WIDTH;
         out_height_ff <= RST_OUT_HEIGHT;
         nw_ff         <= RST_IN_WIDTH;
         nh_ff         <= RST_IN_HEIGHT;
         rw_ff         <= '0;
         rh_ff         <= '0;
         qw_ff         <= '0;
         qh_ff         <= '0;
         sum_vld_ff    <= '0;
         in_col_ff     <= '0;
         in_row_ff     <= '0;
         box_col_ff    <= '0;
         box_row_ff    <= '0;
         col_edge_ff   <= '0;
         col_prev_ff   <= '0;
         col_frac_ff   <= '0;
         row_edge_ff   <= '0;
         row_frac_ff   <= '0;
         band_h_ff     <= '0;
         pix_ff        <= '0;
      end else if (csr_hit) begin
         // any register write restarts the frame after a new division
         unique case (csr_chan.index)
            REG_IN_WIDTH:   in_width_ff   <= csr_chan.data[CFG_IN_W-1:0];
            REG_IN_HEIGHT:  in_height_ff  <= csr_chan.data[CFG_IN_W-1:0];
            REG_OUT_WIDTH:  out_width_ff  <= csr_chan.data[CFG_OUT_W-1:0];
            default:        out_height_ff <= csr_chan.data[CFG_OUT_W-1:0];
         endcase
         nw_ff      <= (csr_chan.index == REG_IN_WIDTH) ? csr_chan.data[CFG_IN_W-1:0]
                                                        : in_width_ff;
         nh_ff      <= (csr_chan.index == REG_IN_HEIGHT) ? csr_chan.data[CFG_IN_W-1:0]
                                                         : in_height_ff;
         rw_ff      <= '0;
         rh_ff      <= '0;
         div_cnt_ff <= '0;
         sum_vld_ff <= '0;
         state_ff   <= F_INIT;
      end else begin
         unique case (state_ff)
            F_INIT: begin
               // one quotient bit per cycle for both axes
               if (tw >= {1'b0, out_width_ff}) begin
                  rw_ff <= tw - {1'b0, out_width_ff};
                  qw_ff <= {qw_ff[CFG_IN_W-2:0], 1'b1};
               end else begin
                  rw_ff <= tw;
                  qw_ff <= {qw_ff[CFG_IN_W-2:0], 1'b0};
               end
               if (th >= {1'b0, out_height_ff}) begin
                  rh_ff <= th - {1'b0, out_height_ff};
                  qh_ff <= {qh_ff[CFG_IN_W-2:0], 1'b1};
               end else begin
                  rh_ff <= th;
                  qh_ff <= {qh_ff[CFG_IN_W-2:0], 1'b0};
               end
               nw_ff <= {nw_ff[CFG_IN_W-2:0], 1'b0};
               nh_ff <= {nh_ff[CFG_IN_W-2:0], 1'b0};
               if (div_cnt_ff == DCW'(CFG_IN_W)) begin
                  // quotients done: hold the results instead of taking another step
                  qw_ff       <= qw_ff;
                  qh_ff       <= qh_ff;
                  rw_ff       <= rw_ff;
                  rh_ff       <= rh_ff;
                  nw_ff       <= nw_ff;
                  nh_ff       <= nh_ff;
                  sum_vld_ff  <= '0;
                  in_col_ff   <= '0;
                  in_row_ff   <= '0;
                  box_col_ff  <= '0;
                  box_row_ff  <= '0;
                  col_edge_ff <= qw_ff;
                  col_prev_ff <= '0;
                  col_frac_ff <= rw_ff[CFG_OUT_W-1:0];
                  row_edge_ff <= qh_ff;
                  row_frac_ff <= rh_ff[CFG_OUT_W-1:0];
                  band_h_ff   <= qh_ff;
                  state_ff    <= F_IDLE;
               end else begin
                  div_cnt_ff <= div_cnt_ff + DCW'(1);
               end
            end
            F_IDLE: begin
               if (req_acc && sizes_ok) begin
                  pix_ff <= req_chan.pixel;
                  if (req_chan.frame_start) begin
                     sum_vld_ff  <= '0;
                     in_col_ff   <= '0;
                     in_row_ff   <= '0;
                     box_col_ff  <= '0;
                     box_row_ff  <= '0;
                     col_edge_ff <= qw_ff;
                     col_prev_ff <= '0;
                     col_frac_ff <= rw_ff[CFG_OUT_W-1:0];
                     row_edge_ff <= qh_ff;
                     row_frac_ff <= rh_ff[CFG_OUT_W-1:0];
                     band_h_ff   <= qh_ff;
                  end
                  state_ff <= F_READ;
               end
            end
            F_READ: begin
               state_ff <= F_UPD;
            end
            default: begin
               sum_vld_ff[box_col_ff] <= 1'b1;
               if (row_wrap) begin
                  in_col_ff   <= '0;
                  box_col_ff  <= '0;
                  col_edge_ff <= qw_ff;
                  col_prev_ff <= '0;
                  col_frac_ff <= rw_ff[CFG_OUT_W-1:0];
                  in_row_ff   <= in_row_ff + IW'(1);
                  if (band_end) begin
                     if (last_band) begin
                        // frame complete, wrap to a fresh frame
                        sum_vld_ff  <= '0;
                        in_row_ff   <= '0;
                        box_row_ff  <= '0;
                        row_edge_ff <= qh_ff;
                        row_frac_ff <= rh_ff[CFG_OUT_W-1:0];
                        band_h_ff   <= qh_ff;
                     end else begin
                        box_row_ff  <= box_row_ff + (COORD_W+1)'(1);
                        row_edge_ff <= row_edge_nx;
                        row_frac_ff <= rh_carry
                                       ? CFG_OUT_W'(row_fsum - {1'b0, out_height_ff})
                                       : row_fsum[CFG_OUT_W-1:0];
                        band_h_ff   <= (row_edge_nx > row_edge_ff) ? (row_edge_nx - row_edge_ff)
                                                                    : CFG_IN_W'(1);
                     end
                  end
               end else begin
                  in_col_ff <= in_col_ff + IW'(1);
                  if (box_end) begin
                     box_col_ff  <= box_col_ff + BCW'(1);
                     col_prev_ff <= col_edge_ff;
                     col_edge_ff <= col_edge_nx;
                     col_frac_ff <= cw_carry
                                    ? CFG_OUT_W'(col_fsum - {1'b0, out_width_ff})
                                    : col_fsum[CFG_OUT_W-1:0];
                  end
               end
               state_ff <= F_IDLE;
            end
         endcase
      end
   end
endmodule

### design/bagd_back.sv
// back part: box mean by shift-subtract division and result register
module bagd_back (
   input  logic                 clock,
   input  logic                 reset,
   input  bagd_pkg::job_type    q_data,
   input  logic                 q_empty,
   output logic                 q_pop,
   bagd_rsp_if.source           rsp_chan
);
   import bagd_pkg::*;

   localparam int DW = PROD_W + PIX_W - 1;

   typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_OUT} bstate_type;

   bstate_type           state_ff;
   job_type              job_ff;
   logic [DW-1:0]        dsh_ff;
   logic [SUM_W-1:0]     rem_ff;
   logic [PIX_W-1:0]     quo_ff;
   logic [2:0]           cnt_ff;
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     mean_ff;
   logic [COORD_W-1:0]   x_ff, y_ff;
   logic                 done_ff, status_ff;
   logic [PROD_W-1:0]    area;
   logic                 fits, out_free;

   assign area     = PROD_W'(job_ff.w) * PROD_W'(job_ff.h);
   assign fits     = {{(DW-SUM_W){1'b0}}, rem_ff} >= dsh_ff;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop    = (state_ff == B_IDLE) && !q_empty;

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.mean_value = mean_ff;
   assign rsp_chan.out_x      = x_ff;
   assign rsp_chan.out_y      = y_ff;
   assign rsp_chan.frame_done = done_ff;
   assign rsp_chan.status     = status_ff;

   // job sequencer and output register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
         job_ff       <= '0;
         dsh_ff       <= '0;
         rem_ff       <= '0;
         quo_ff       <= '0;
         cnt_ff       <= '0;
         mean_ff      <= '0;
         x_ff         <= '0;
         y_ff         <= '0;
         done_ff      <= 1'b0;
         status_ff    <= STATUS_OK;
      end else begin
         if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (!q_empty) begin
                  job_ff   <= q_data;
                  quo_ff   <= '0;
                  state_ff <= (q_data.status == STATUS_BAD_CFG) ? B_OUT : B_MUL;
               end
            end
            B_MUL: begin
               dsh_ff   <= {area, {(PIX_W-1){1'b0}}};
               rem_ff   <= job_ff.sum;
               cnt_ff   <= '0;
               state_ff <= B_DIV;
            end
            B_DIV: begin
               // one quotient bit per cycle, most significant first
               if (fits) begin
                  rem_ff <= rem_ff - SUM_W'(dsh_ff);
               end
               quo_ff <= {quo_ff[PIX_W-2:0], fits};
               dsh_ff <= dsh_ff >> 1;
               cnt_ff <= cnt_ff + 3'd1;
               if (cnt_ff == 3'(PIX_W - 1)) begin
                  state_ff <= B_OUT;
               end
            end
            default: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= job_ff.status;
                  if (job_ff.status == STATUS_BAD_CFG) begin
                     mean_ff <= '0;
                     x_ff    <= '0;
                     y_ff    <= '0;
                     done_ff <= 1'b0;
                  end else begin
                     mean_ff <= quo_ff;
                     x_ff    <= job_ff.x;
                     y_ff    <= job_ff.y;
                     done_ff <= job_ff.done;
                  end
                  state_ff <= B_IDLE;
               end
            end
         endcase
      end
   end
endmodule

### design/box_average_grayscale_downscaler.sv
// top level of the box average grayscale downscaler
//
// channel   dir   handshake         payload
// req_chan  in    valid / ready     pixel, frame_start
// rsp_chan  out   valid / ready     mean_value, out_x, out_y, frame_done, status
// csr_chan  in    valid / ready     index, data
//
// the front handles each pixel by accept, column sum read and update, and takes
// no new pixel until the update is done; each box result then passes through the
// back's shift-subtract divider (an error item skips it), so with one-pixel boxes
// the divider sets the rate; a 4-entry queue parts them
// after reset and after each register write the front runs the edge step division
// and takes no pixel until it is done; register writes are always taken
// rsp stalls back up through the queue into req ready
module box_average_grayscale_downscaler #(
   parameter int MAX_IN_SIZE  = bagd_pkg::DEF_MAX_IN_SIZE,
   parameter int MAX_OUT_SIZE = bagd_pkg::DEF_MAX_OUT_SIZE
) (
   input  logic      clock,
   input  logic      reset,
   bagd_req_if.sink  req_chan,
   bagd_rsp_if.source rsp_chan,
   bagd_csr_if.sink  csr_chan
);
   import bagd_pkg::*;

   q_ctrl_type q_ctrl;
   q_stat_type q_stat;
   job_type    q_wr, q_rd;

   // front: configuration and accumulation
   bagd_front #(
      .MAX_IN_SIZE  (MAX_IN_SIZE),
      .MAX_OUT_SIZE (MAX_OUT_SIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .csr_chan (csr_chan),
      .q_push   (q_ctrl.push),
      .q_data   (q_wr),
      .q_full   (q_stat.full)
   );

   // job queue
   bagd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (q_ctrl),
      .wr_data (q_wr),
      .rd_data (q_rd),
      .stat    (q_stat)
   );

   // back: division and result
   bagd_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_data   (q_rd),
      .q_empty  (q_stat.empty),
      .q_pop    (q_ctrl.pop),
      .rsp_chan (rsp_chan)
   );
endmodule
